>>> hdl/bacr_pkg.sv
// Shared types, constants and the fixed palette for the bitmap/attribute cell renderer.
// Used by the controller, the datapath and the top level; depends on nothing else.
package bacr_pkg;

    // Screen store geometry.
    localparam int StoreDepth   = 6912;
    localparam int AddrW        = 13;
    localparam int DisplayLines = 192;
    localparam logic [AddrW-1:0] AttrBase  = 13'h1800;
    localparam logic [AddrW-1:0] StoreLast = 13'(StoreDepth - 1);

    // Item operation codes.
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;   // clearing pass: write zero at the sweep address
        logic wr_en;    // write beat accepted this cycle
        logic cap_en;   // capture line and column of an accepted beat
        logic rd_attr;  // read address selects the attribute byte
        logic pix_ld;   // load the bitmap byte from the read data
        logic attr_ld;  // load the attribute byte from the read data
        logic bit_clr;  // restart the pixel counter
        logic bit_inc;  // advance to the next pixel
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last; // sweep address is at the last entry
        logic line_ok;  // input line lies on the display
        logic bit_last; // current pixel is the eighth of the row
    } status_t;

    // Fixed 16-entry palette, returned as {red, green, blue}.
    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        unique case (idx)
            4'd0:  rgb = {8'd0,   8'd0,   8'd0};
            4'd1:  rgb = {8'd1,   8'd0,   8'd206};
            4'd2:  rgb = {8'd207, 8'd1,   8'd0};
            4'd3:  rgb = {8'd207, 8'd1,   8'd206};
            4'd4:  rgb = {8'd0,   8'd207, 8'd21};
            4'd5:  rgb = {8'd1,   8'd207, 8'd207};
            4'd6:  rgb = {8'd207, 8'd207, 8'd21};
            4'd7:  rgb = {8'd207, 8'd207, 8'd207};
            4'd8:  rgb = {8'd0,   8'd0,   8'd0};
            4'd9:  rgb = {8'd2,   8'd0,   8'd253};
            4'd10: rgb = {8'd255, 8'd2,   8'd1};
            4'd11: rgb = {8'd255, 8'd2,   8'd253};
            4'd12: rgb = {8'd0,   8'd255, 8'd28};
            4'd13: rgb = {8'd2,   8'd255, 8'd255};
            4'd14: rgb = {8'd255, 8'd241, 8'd29};
            4'd15: rgb = {8'd255, 8'd255, 8'd255};
            default: rgb = 24'd0;
        endcase
        return rgb;
    endfunction

endpackage

>>> hdl/bitmap_attribute_cell_render_core.sv
// Bitmap/attribute cell renderer: a write beat stores one screen byte if in range.
// A render beat reads the bitmap and then the attribute byte through the single store
// read port; after the RD_BMP, RD_ATTR and LOAD states the first pixel is presented,
// then one pixel per cycle while m_ready holds; the next beat is taken after the eighth.
// After reset all 6912 store bytes are cleared, one byte per cycle, with s_ready low.
module bitmap_attribute_cell_render_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [12:0] s_write_offset,
    input  logic [7:0]  s_write_data,
    input  logic [7:0]  s_line,
    input  logic [4:0]  s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel_x,
    output logic [7:0]  m_pixel_y,
    output logic [3:0]  m_color_index,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic        m_last
);

    bacr_pkg::cmd_t    cmd;
    bacr_pkg::status_t status;

    // Sequencing.
    bacr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Store and pixel generation.
    bacr_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_write_offset (s_write_offset),
        .s_write_data   (s_write_data),
        .s_line         (s_line),
        .s_column       (s_column),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_color_index  (m_color_index),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_last         (m_last)
    );

endmodule

>>> hdl/bacr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependencies.
module bacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bacr_ctrl.sv
// Controller state machine: clearing pass, beat acceptance, read sequence and pixel output.
// Depends on bacr_pkg for the command and status types.
module bacr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_op,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  bacr_pkg::status_t status,
    output bacr_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_BMP,
        ST_RD_ATTR,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;
    logic   in_beat;
    logic   is_render;

    assign in_beat   = s_valid && s_ready_reg;
    assign is_render = (bacr_pkg::op_t'(s_op) == bacr_pkg::OP_RENDER);

    // State and registered handshake outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (status.clr_last) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_beat && is_render && status.line_ok) begin
                        state_reg   <= ST_RD_BMP;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_RD_BMP: begin
                    state_reg <= ST_RD_ATTR;
                end
                ST_RD_ATTR: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    state_reg   <= ST_EMIT;
                    m_valid_reg <= 1'b1;
                end
                ST_EMIT: begin
                    if (m_ready && status.bit_last) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // Datapath commands decoded from the state.
    always_comb begin
        cmd         = '0;
        cmd.clr_en  = (state_reg == ST_CLEAR);
        cmd.wr_en   = (state_reg == ST_IDLE) && in_beat && !is_render;
        cmd.cap_en  = (state_reg == ST_IDLE) && in_beat;
        cmd.rd_attr = (state_reg == ST_RD_ATTR);
        cmd.pix_ld  = (state_reg == ST_RD_ATTR);
        cmd.attr_ld = (state_reg == ST_LOAD);
        cmd.bit_clr = (state_reg == ST_LOAD);
        cmd.bit_inc = (state_reg == ST_EMIT) && m_ready;
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

>>> hdl/bacr_datapath.sv
// Datapath: screen store, clearing sweep, address forming, byte registers and pixel decode.
// Depends on bacr_pkg and instantiates bacr_ram.
module bacr_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  bacr_pkg::cmd_t    cmd,
    output bacr_pkg::status_t status,
    input  logic [12:0]       s_write_offset,
    input  logic [7:0]        s_write_data,
    input  logic [7:0]        s_line,
    input  logic [4:0]        s_column,
    output logic [7:0]        m_pixel_x,
    output logic [7:0]        m_pixel_y,
    output logic [3:0]        m_color_index,
    output logic [7:0]        m_red,
    output logic [7:0]        m_green,
    output logic [7:0]        m_blue,
    output logic              m_last
);

    logic [bacr_pkg::AddrW-1:0] clr_cnt_reg;
    logic [bacr_pkg::AddrW-1:0] clr_cnt_next;
    logic [7:0]                 line_reg;
    logic [4:0]                 col_reg;
    logic [7:0]                 pix_reg;
    logic [7:0]                 attr_reg;
    logic [2:0]                 bit_reg;
    logic [2:0]                 bit_next;
    logic                       ram_we;
    logic [bacr_pkg::AddrW-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic [bacr_pkg::AddrW-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;
    logic [bacr_pkg::AddrW-1:0] bmp_addr;
    logic [bacr_pkg::AddrW-1:0] attr_rd_addr;
    logic                       pix_set;
    logic [23:0]                rgb;

    function automatic logic [7:0] s_line_bits(input logic [7:0] ln);
        return {ln[7:6], ln[2:0], ln[5:3]};
    endfunction

    // Clearing sweep counter, one entry per cycle after reset.
    assign clr_cnt_next = cmd.clr_en ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Write port: zeros during the sweep, otherwise in-range write beats.
    always_comb begin
        if (cmd.clr_en) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 8'd0;
        end else begin
            ram_we    = cmd.wr_en && (s_write_offset <= bacr_pkg::StoreLast);
            ram_waddr = s_write_offset;
            ram_wdata = s_write_data;
        end
    end

    // Interleaved bitmap address and linear attribute address.
    assign bmp_addr     = {s_line_bits(line_reg), col_reg};
    assign attr_rd_addr = bacr_pkg::AttrBase + {3'd0, line_reg[7:3], col_reg};
    assign ram_raddr    = cmd.rd_attr ? attr_rd_addr : bmp_addr;

    bacr_ram #(
        .WIDTH(8),
        .DEPTH(bacr_pkg::StoreDepth)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Item capture and fetched byte registers.
    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            line_reg <= s_line;
            col_reg  <= s_column;
        end
        if (cmd.pix_ld) begin
            pix_reg <= ram_rdata;
        end
        if (cmd.attr_ld) begin
            attr_reg <= ram_rdata;
        end
    end

    // Pixel counter within the cell row.
    always_comb begin
        priority if (cmd.bit_clr) begin
            bit_next = 3'd0;
        end else if (cmd.bit_inc) begin
            bit_next = bit_reg + 3'd1;
        end else begin
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= '0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    // Pixel decode: most significant bit first, ink when set, bright (attribute bit 7) picks the upper half.
    assign pix_set       = pix_reg[3'd7 - bit_reg];
    assign m_color_index = {attr_reg[7], pix_set ? attr_reg[2:0] : attr_reg[5:3]};
    assign rgb           = bacr_pkg::palette_rgb(m_color_index);
    assign m_red         = rgb[23:16];
    assign m_green       = rgb[15:8];
    assign m_blue        = rgb[7:0];
    assign m_pixel_x     = {col_reg, bit_reg};
    assign m_pixel_y     = line_reg;
    assign m_last        = (bit_reg == 3'd7);

    // Status back to the controller.
    assign status.clr_last = (clr_cnt_reg == bacr_pkg::StoreLast);
    assign status.line_ok  = (s_line < 8'(bacr_pkg::DisplayLines));
    assign status.bit_last = (bit_reg == 3'd7);

endmodule

>>> hdl/bacr_checker.sv
// Port-level checks for the cell renderer, attached to the top level by bind.
// Depends only on the top level's ports.
module bacr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_pixel_x,
    input logic [7:0] m_pixel_y,
    input logic [3:0] m_color_index,
    input logic       m_last
);

    // A stalled pixel beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_color_index) && $stable(m_last))
        else $error("pixel beat changed while stalled");

    // Input is never taken while a cell row is being delivered.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready during pixel output");

    // Pixels of one row follow left to right on the same line.
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_pixel_y == $past(m_pixel_y)
            && m_pixel_x == $past(m_pixel_x) + 8'd1)
        else $error("pixel sequence broken");

    // The eighth pixel ends the row.
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("output continued after last pixel");

    // Reset drops both s_ready and m_valid.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("handshake active after reset");

endmodule

bind bitmap_attribute_cell_render_core bacr_checker u_bacr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_x     (m_pixel_x),
    .m_pixel_y     (m_pixel_y),
    .m_color_index (m_color_index),
    .m_last        (m_last)
);
